@@ hw/rtl/adam_parameter_update_unit_assert.svh @@
// ----------------------------------------------------------------------------
// adam parameter update unit assertion macros
// implication and next-cycle implication checks on a clock and active-low reset
// ----------------------------------------------------------------------------
`ifndef ADAM_PARAMETER_UPDATE_UNIT_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define APU_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

`define APU_ASSERT_NXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`else

`define APU_ASSERT_IMP(lbl, clk, rst_n, a, c, msg)

`define APU_ASSERT_NXT(lbl, clk, rst_n, a, c, msg)

`endif

`endif

@@ hw/rtl/apu_pkg.sv @@
// ----------------------------------------------------------------------------
// adam parameter update package
// field widths, register codes and the item record carried down the pipeline
// ----------------------------------------------------------------------------
package apu_pkg;

	localparam int IDX_W      = 12;
	localparam int DATA_W     = 32;
	localparam int V_W        = 64;
	localparam int TDATA_W    = 80;
	localparam int CFG_W      = 24;
	localparam int CFG_IDX_W  = 2;
	localparam int FRAC_W     = 16;
	localparam int RATE_W     = 24;

	// integer square root: 32 result bits, two per stage
	localparam int ROOT_W     = 32;
	localparam int SQ_PER     = 2;
	localparam int SQ_STAGES  = ROOT_W / SQ_PER;
	localparam int SQ_REM_W   = 34;

	// restoring divider: 48 quotient bits, two per stage
	localparam int DIV_W      = 48;
	localparam int DV_PER     = 2;
	localparam int DV_STAGES  = DIV_W / DV_PER;
	localparam int DEN_W      = 33;

	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BETA1 = 2'd0,
		REG_BETA2 = 2'd1,
		REG_EPS   = 2'd2,
		REG_RATE  = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [DATA_W-1:0] w;
		logic                     m_neg;
		logic [DATA_W-1:0]        m_mag;
	} item_t;

endpackage

@@ hw/rtl/adam_parameter_update_unit.sv @@
// ----------------------------------------------------------------------------
// adam parameter update unit
// throughput: one item per cycle while the output register can take an item, set by the moment read-modify-write
// reset: a clearing pass over all PARAM_COUNT slots zeroes both moment memories,
// input tready stays low during it, configuration writes are taken as ever
// ----------------------------------------------------------------------------
`include "adam_parameter_update_unit_assert.svh"

module adam_parameter_update_unit #(
	parameter int PARAM_COUNT = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// index[11:0], gradient[43:12], weight_in[75:44], zero fill
	input  logic [apu_pkg::TDATA_W-1:0]     s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// index_out[11:0], weight_out[43:12], scaled_step[75:44], zero fill
	output logic [apu_pkg::TDATA_W-1:0]     m_axis_tdata,
	input  logic                            cfg_we,
	input  logic [apu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [apu_pkg::CFG_W-1:0]       cfg_data
);
	import apu_pkg::*;

	localparam int AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam logic [AW-1:0] LAST_SLOT = AW'(PARAM_COUNT - 1);

	// configuration
	logic [FRAC_W-1:0] b1_q, b2_q, eps_q;
	logic [RATE_W-1:0] rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_q   <= 16'd6554;
			b2_q   <= 16'd66;
			eps_q  <= 16'd1;
			rate_q <= 24'd16777;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BETA1: b1_q   <= cfg_data[FRAC_W-1:0];
				REG_BETA2: b2_q   <= cfg_data[FRAC_W-1:0];
				REG_EPS:   eps_q  <= cfg_data[FRAC_W-1:0];
				REG_RATE:  rate_q <= cfg_data[RATE_W-1:0];
				default:   ;
			endcase
		end
	end

	// pipeline advance: whole pipe moves when the output register can take an item
	logic adv;
	logic clearing_q;
	logic [AW-1:0] clr_q;

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv && !clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == LAST_SLOT) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---------------- stage 1: slot and gradient square ----------------
	logic [IDX_W-1:0]         in_idx;
	logic signed [DATA_W-1:0] in_g, in_w;
	logic [DATA_W-1:0]        in_gmag;
	logic [AW-1:0]            in_slot;

	assign in_idx  = s_axis_tdata[IDX_W-1:0];
	assign in_g    = s_axis_tdata[IDX_W+DATA_W-1:IDX_W];
	assign in_w    = s_axis_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
	assign in_gmag = in_g[DATA_W-1] ? DATA_W'(-in_g) : DATA_W'(in_g);

	generate
		if (PARAM_COUNT == 1) begin : g_mod_one
			assign in_slot = '0;
		end else if (((PARAM_COUNT & (PARAM_COUNT - 1)) == 0) ||
				(PARAM_COUNT >= (1 << IDX_W))) begin : g_mod_cut
			assign in_slot = AW'(in_idx);
		end else begin : g_mod_rcp
			// floor reciprocal underestimates the quotient by at most one
			localparam longint RCP = (64'd1 << 24) / PARAM_COUNT;
			logic [36:0] prod;
			logic [12:0] quo, rm, rm_fix;
			always_comb begin
				prod   = {25'd0, in_idx} * 37'(RCP);
				quo    = prod[36:24];
				rm     = {1'b0, in_idx} - 13'(quo * 13'(PARAM_COUNT));
				rm_fix = (rm >= 13'(PARAM_COUNT)) ? rm - 13'(PARAM_COUNT) : rm;
			end
			assign in_slot = AW'(rm_fix);
		end
	endgenerate

	logic                     vld_s1;
	logic [IDX_W-1:0]         idx_s1;
	logic signed [DATA_W-1:0] g_s1, w_s1;
	logic [AW-1:0]            slot_s1;
	logic [V_W-1:0]           gg_s1;

	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			idx_s1  <= in_idx;
			g_s1    <= in_g;
			w_s1    <= in_w;
			slot_s1 <= in_slot;
			gg_s1   <= in_gmag * in_gmag;
		end
	end

	// ---------------- stage 2: moment read-modify-write ----------------
	logic signed [DATA_W-1:0] mem_m [0:PARAM_COUNT-1];
	logic [V_W-1:0]           mem_v [0:PARAM_COUNT-1];

	logic                     vld_s2;
	logic [IDX_W-1:0]         idx_s2;
	logic signed [DATA_W-1:0] g_s2, w_s2, m_rd_s2;
	logic [AW-1:0]            slot_s2;
	logic [V_W-1:0]           gg_s2, v_rd_s2;

	logic                     mem_we;
	logic [AW-1:0]            mem_wa;
	logic signed [DATA_W-1:0] mem_wm, m_new;
	logic [V_W-1:0]           mem_wv, v_new;

	// latest write, for an item whose read raced the previous item's write
	logic [AW-1:0]            fwd_slot_q;
	logic signed [DATA_W-1:0] fwd_m_q;
	logic [V_W-1:0]           fwd_v_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			m_rd_s2 <= mem_m[slot_s1];
			v_rd_s2 <= mem_v[slot_s1];
			idx_s2  <= idx_s1;
			g_s2    <= g_s1;
			w_s2    <= w_s1;
			slot_s2 <= slot_s1;
			gg_s2   <= gg_s1;
		end
		if (mem_we) begin
			mem_m[mem_wa] <= mem_wm;
			mem_v[mem_wa] <= mem_wv;
			fwd_slot_q    <= mem_wa;
			fwd_m_q       <= mem_wm;
			fwd_v_q       <= mem_wv;
		end
	end

	logic signed [DATA_W-1:0] m_cur;
	logic [V_W-1:0]           v_cur, v_diff;
	logic signed [DATA_W:0]   dm;
	logic [DATA_W:0]          dm_mag;
	logic [DATA_W+FRAC_W:0]   pm;
	logic signed [DATA_W+1:0] m_sum;
	logic [V_W+FRAC_W-1:0]    pv;
	logic [V_W-1:0]           qv;
	logic [V_W:0]             v_up;

	always_comb begin
		m_cur  = (fwd_slot_q == slot_s2) ? fwd_m_q : m_rd_s2;
		v_cur  = (fwd_slot_q == slot_s2) ? fwd_v_q : v_rd_s2;

		dm     = {g_s2[DATA_W-1], g_s2} - {m_cur[DATA_W-1], m_cur};
		dm_mag = dm[DATA_W] ? (DATA_W+1)'(-dm) : (DATA_W+1)'(dm);
		pm     = (DATA_W+FRAC_W+1)'(dm_mag * b1_q) + (DATA_W+FRAC_W+1)'(1 << (FRAC_W-1));
		m_sum  = dm[DATA_W] ? (DATA_W+2)'(m_cur) - $signed({1'b0, pm[DATA_W+FRAC_W:FRAC_W]})
				: (DATA_W+2)'(m_cur) + $signed({1'b0, pm[DATA_W+FRAC_W:FRAC_W]});
		if (m_sum > (DATA_W+2)'(S32_MAX)) begin
			m_new = S32_MAX;
		end else if (m_sum < (DATA_W+2)'(S32_MIN)) begin
			m_new = S32_MIN;
		end else begin
			m_new = DATA_W'(m_sum);
		end

		v_diff = (gg_s2 >= v_cur) ? gg_s2 - v_cur : v_cur - gg_s2;
		pv     = (V_W+FRAC_W)'(v_diff * b2_q) + (V_W+FRAC_W)'(1 << (FRAC_W-1));
		qv     = pv[V_W+FRAC_W-1:FRAC_W];
		v_up   = {1'b0, v_cur} + {1'b0, qv};
		if (gg_s2 >= v_cur) begin
			v_new = v_up[V_W] ? '1 : v_up[V_W-1:0];
		end else begin
			v_new = (qv > v_cur) ? '0 : v_cur - qv;
		end

		mem_we = clearing_q || (vld_s2 && adv);
		mem_wa = clearing_q ? clr_q : slot_s2;
		mem_wm = clearing_q ? '0 : m_new;
		mem_wv = clearing_q ? '0 : v_new;
	end

	// ---------------- square root pipeline ----------------
	logic                vld_sq  [0:SQ_STAGES];
	item_t               it_sq   [0:SQ_STAGES];
	logic [V_W-1:0]      x_sq    [0:SQ_STAGES];
	logic [SQ_REM_W-1:0] rem_sq  [0:SQ_STAGES];
	logic [ROOT_W-1:0]   root_sq [0:SQ_STAGES];

	logic [V_W-1:0]      x_sq_nx    [0:SQ_STAGES-1];
	logic [SQ_REM_W-1:0] rem_sq_nx  [0:SQ_STAGES-1];
	logic [ROOT_W-1:0]   root_sq_nx [0:SQ_STAGES-1];

	item_t item_s2;
	assign item_s2.idx   = idx_s2;
	assign item_s2.w     = w_s2;
	assign item_s2.m_neg = m_new[DATA_W-1];
	assign item_s2.m_mag = m_new[DATA_W-1] ? DATA_W'(-m_new) : DATA_W'(m_new);

	always_comb begin
		logic [V_W-1:0]        x;
		logic [SQ_REM_W-1:0]   rem;
		logic [ROOT_W-1:0]     root;
		logic [SQ_REM_W+1:0]   rem2, trial;
		for (int k = 0; k < SQ_STAGES; k++) begin
			x    = x_sq[k];
			rem  = rem_sq[k];
			root = root_sq[k];
			for (int j = 0; j < SQ_PER; j++) begin
				rem2  = {rem, x[V_W-1:V_W-2]};
				trial = (SQ_REM_W+2)'({root, 2'b01});
				if (rem2 >= trial) begin
					rem  = SQ_REM_W'(rem2 - trial);
					root = {root[ROOT_W-2:0], 1'b1};
				end else begin
					rem  = SQ_REM_W'(rem2);
					root = {root[ROOT_W-2:0], 1'b0};
				end
				x = {x[V_W-3:0], 2'b00};
			end
			x_sq_nx[k]    = x;
			rem_sq_nx[k]  = rem;
			root_sq_nx[k] = root;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_sq[0]   <= item_s2;
			x_sq[0]    <= v_new;
			rem_sq[0]  <= '0;
			root_sq[0] <= '0;
			for (int k = 0; k < SQ_STAGES; k++) begin
				it_sq[k+1]   <= it_sq[k];
				x_sq[k+1]    <= x_sq_nx[k];
				rem_sq[k+1]  <= rem_sq_nx[k];
				root_sq[k+1] <= root_sq_nx[k];
			end
		end
	end

	// ---------------- divider pipeline ----------------
	logic               vld_dv [0:DV_STAGES];
	item_t              it_dv  [0:DV_STAGES];
	logic               zden_dv[0:DV_STAGES];
	logic [DEN_W-1:0]   den_dv [0:DV_STAGES];
	logic [DIV_W-1:0]   num_dv [0:DV_STAGES];
	logic [DIV_W-1:0]   quo_dv [0:DV_STAGES];
	logic [DEN_W-1:0]   rem_dv [0:DV_STAGES];

	logic [DIV_W-1:0]   num_dv_nx [0:DV_STAGES-1];
	logic [DIV_W-1:0]   quo_dv_nx [0:DV_STAGES-1];
	logic [DEN_W-1:0]   rem_dv_nx [0:DV_STAGES-1];

	logic [DEN_W-1:0]   den_in;
	logic [DIV_W-1:0]   num_in;

	// rounded quotient: numerator carries half the denominator
	assign den_in = {1'b0, root_sq[SQ_STAGES]} + DEN_W'(eps_q);
	assign num_in = {it_sq[SQ_STAGES].m_mag, {FRAC_W{1'b0}}} + DIV_W'(den_in >> 1);

	always_comb begin
		logic [DIV_W-1:0] n, q;
		logic [DEN_W-1:0] r;
		logic [DEN_W:0]   r2;
		for (int k = 0; k < DV_STAGES; k++) begin
			n = num_dv[k];
			q = quo_dv[k];
			r = rem_dv[k];
			for (int j = 0; j < DV_PER; j++) begin
				r2 = {r, n[DIV_W-1]};
				if (r2 >= {1'b0, den_dv[k]}) begin
					r = DEN_W'(r2 - {1'b0, den_dv[k]});
					q = {q[DIV_W-2:0], 1'b1};
				end else begin
					r = DEN_W'(r2);
					q = {q[DIV_W-2:0], 1'b0};
				end
				n = {n[DIV_W-2:0], 1'b0};
			end
			num_dv_nx[k] = n;
			quo_dv_nx[k] = q;
			rem_dv_nx[k] = r;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_dv[0]   <= it_sq[SQ_STAGES];
			zden_dv[0] <= (den_in == '0);
			den_dv[0]  <= den_in;
			num_dv[0]  <= num_in;
			quo_dv[0]  <= '0;
			rem_dv[0]  <= '0;
			for (int k = 0; k < DV_STAGES; k++) begin
				it_dv[k+1]   <= it_dv[k];
				zden_dv[k+1] <= zden_dv[k];
				den_dv[k+1]  <= den_dv[k];
				num_dv[k+1]  <= num_dv_nx[k];
				quo_dv[k+1]  <= quo_dv_nx[k];
				rem_dv[k+1]  <= rem_dv_nx[k];
			end
		end
	end

	// ---------------- step, rate product, weight ----------------
	item_t                    it_dn;
	logic [DIV_W-1:0]         quo_dn;
	logic                     big_dn;
	logic signed [DATA_W-1:0] step_nx;

	assign it_dn  = it_dv[DV_STAGES];
	assign quo_dn = quo_dv[DV_STAGES];
	assign big_dn = (quo_dn >= (DIV_W'(1) << (DATA_W-1)));

	always_comb begin
		if (zden_dv[DV_STAGES]) begin
			if (it_dn.m_mag == '0) begin
				step_nx = '0;
			end else begin
				step_nx = it_dn.m_neg ? S32_MIN : S32_MAX;
			end
		end else if (it_dn.m_neg) begin
			step_nx = big_dn ? S32_MIN : -$signed(quo_dn[DATA_W-1:0]);
		end else begin
			step_nx = big_dn ? S32_MAX : $signed(quo_dn[DATA_W-1:0]);
		end
	end

	logic                     vld_st, vld_mu;
	item_t                    it_st, it_mu;
	logic signed [DATA_W-1:0] step_st, step_mu;
	logic [DATA_W-1:0]        smag_st, upd_mu;
	logic [DATA_W+RATE_W-1:0] prod_mu;

	assign prod_mu = (DATA_W+RATE_W)'(smag_st * rate_q)
			+ (DATA_W+RATE_W)'(1 << (RATE_W-1));

	always_ff @(posedge clk) begin
		if (adv) begin
			it_st   <= it_dn;
			step_st <= step_nx;
			smag_st <= step_nx[DATA_W-1] ? DATA_W'(-step_nx) : DATA_W'(step_nx);
			it_mu   <= it_st;
			step_mu <= step_st;
			upd_mu  <= prod_mu[DATA_W+RATE_W-1:RATE_W];
		end
	end

	logic signed [DATA_W+1:0] w_sum;
	logic signed [DATA_W-1:0] w_out;

	always_comb begin
		w_sum = step_mu[DATA_W-1] ? (DATA_W+2)'(it_mu.w) + $signed({2'b00, upd_mu})
				: (DATA_W+2)'(it_mu.w) - $signed({2'b00, upd_mu});
		if (w_sum > (DATA_W+2)'(S32_MAX)) begin
			w_out = S32_MAX;
		end else if (w_sum < (DATA_W+2)'(S32_MIN)) begin
			w_out = S32_MIN;
		end else begin
			w_out = DATA_W'(w_sum);
		end
	end

	logic [TDATA_W-1:0] out_data_q;
	logic               out_vld_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {(TDATA_W-IDX_W-2*DATA_W)'(0), step_mu, w_out, it_mu.idx};
		end
	end

	assign m_axis_tdata  = out_data_q;
	assign m_axis_tvalid = out_vld_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_st    <= 1'b0;
			vld_mu    <= 1'b0;
			out_vld_q <= 1'b0;
			for (int k = 0; k <= SQ_STAGES; k++) begin
				vld_sq[k] <= 1'b0;
			end
			for (int k = 0; k <= DV_STAGES; k++) begin
				vld_dv[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1    <= s_axis_tvalid && s_axis_tready;
			vld_s2    <= vld_s1;
			vld_sq[0] <= vld_s2;
			for (int k = 0; k < SQ_STAGES; k++) begin
				vld_sq[k+1] <= vld_sq[k];
			end
			vld_dv[0] <= vld_sq[SQ_STAGES];
			for (int k = 0; k < DV_STAGES; k++) begin
				vld_dv[k+1] <= vld_dv[k];
			end
			vld_st    <= vld_dv[DV_STAGES];
			vld_mu    <= vld_st;
			out_vld_q <= vld_mu;
		end
	end

	`APU_ASSERT_IMP(a_no_accept_clearing, clk, arst_n, clearing_q, !s_axis_tready, "item accepted during clearing pass")
	`APU_ASSERT_IMP(a_no_item_clearing, clk, arst_n, clearing_q, !vld_s1 && !vld_s2, "item in moment stages during clearing")
	`APU_ASSERT_NXT(a_clear_last, clk, arst_n, clearing_q && clr_q == LAST_SLOT, !clearing_q, "clearing pass overran")
	`APU_ASSERT_IMP(a_zden_eps, clk, arst_n, vld_dv[0] && zden_dv[0], eps_q == '0, "zero denominator with nonzero epsilon")

endmodule

@@ verif/adam_parameter_update_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adam parameter update unit testbench
// streams gradient items through the block, predicts each updated weight and
// step from a local copy of the moment memories, and checks every result item
// ----------------------------------------------------------------------------
module adam_parameter_update_unit_test;
	import apu_pkg::*;

	localparam int NUM_SLOTS = 4096;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] weight;
		logic [DATA_W-1:0] step;
	} update_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [TDATA_W-1:0]   s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [TDATA_W-1:0]   m_axis_tdata;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// predictor state
	longint          moment1 [NUM_SLOTS];
	logic [63:0]     moment2 [NUM_SLOTS];
	logic [15:0]     blend1, blend2, eps_val;
	logic [23:0]     rate_val;

	update_t         pending_updates[$];
	bit              failed;
	bit              no_idle;
	bit              hold_request;
	int              hold_left;

	adam_parameter_update_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	function automatic logic [63:0] magnitude(longint x);
		return x < 0 ? 64'd0 - 64'(x) : 64'(x);
	endfunction

	// rounded a*f/2^s, split so the product never overflows
	function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] f, int s);
		logic [63:0] hi, lo;
		hi = a >> s;
		lo = a & ((64'd1 << s) - 64'd1);
		return hi * f + ((lo * f + (64'd1 << (s - 1))) >> s);
	endfunction

	function automatic logic [63:0] floor_root(logic [63:0] x);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic update_t adam_update(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] g_bits,
			logic [DATA_W-1:0] w_bits);
		update_t     res;
		int          slot;
		longint      g, w, m, dm, denom, step, upd;
		logic [63:0] v, gg, q, num, r, sum;
		slot = idx % NUM_SLOTS;
		g = longint'($signed(g_bits));
		w = longint'($signed(w_bits));
		m = moment1[slot];
		v = moment2[slot];
		dm = g - m;
		q = scale_round(magnitude(dm), 64'(blend1), 16);
		m = dm < 0 ? m - longint'(q) : m + longint'(q);
		m = clamp32(m);
		moment1[slot] = m;
		gg = magnitude(g) * magnitude(g);
		if (gg >= v) begin
			q = scale_round(gg - v, 64'(blend2), 16);
			sum = v + q;
			v = (sum < v) ? 64'hffff_ffff_ffff_ffff : sum;
		end else begin
			q = scale_round(v - gg, 64'(blend2), 16);
			v = (q > v) ? 64'd0 : v - q;
		end
		moment2[slot] = v;
		r = floor_root(v);
		denom = longint'(r) + longint'(eps_val);
		if (denom == 0) begin
			step = m > 0 ? 64'sd2147483647 : (m < 0 ? -64'sd2147483648 : 0);
		end else begin
			num = magnitude(m) << 16;
			q = (num + (64'(denom) >> 1)) / 64'(denom);
			if (q > (64'd1 << 32)) q = 64'd1 << 32;
			step = m < 0 ? -longint'(q) : longint'(q);
			step = clamp32(step);
		end
		q = scale_round(magnitude(step), 64'(rate_val), 24);
		upd = step < 0 ? -longint'(q) : longint'(q);
		w = clamp32(w - upd);
		res.idx = idx;
		res.weight = w[31:0];
		res.step = step[31:0];
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_item(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] g, logic [DATA_W-1:0] w);
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, w, g, idx};
		do @(posedge clk); while (!s_axis_tready);
		pending_updates.push_back(adam_update(idx, g, w));
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// write enable stays high across a burst; the caller drops it at the end
	task automatic write_reg(cfg_reg_t which, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		@(posedge clk);
		case (which)
			REG_BETA1: blend1 = value[15:0];
			REG_BETA2: blend2 = value[15:0];
			REG_EPS:   eps_val = value[15:0];
			REG_RATE:  rate_val = value[23:0];
			default:   ;
		endcase
	endtask

	task automatic set_all(logic [15:0] b1, logic [15:0] b2, logic [15:0] e, logic [23:0] lr);
		write_reg(REG_BETA1, CFG_W'(b1));
		write_reg(REG_BETA2, CFG_W'(b2));
		write_reg(REG_EPS, CFG_W'(e));
		write_reg(REG_RATE, lr);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [DATA_W-1:0] random_gradient();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return DATA_W'($signed($urandom_range(0, 131071)) - 65536);
			2: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
			default: return DATA_W'($signed($urandom_range(0, 2097151)) - 1048576);
		endcase
	endfunction

	task automatic test_reset_values();
		send_item(12'd5, 32'h0001_0000, 32'h0002_0000);
		send_item(12'd5, 32'hffff_0000, 32'h0002_0000);
		send_item(12'd0, 32'h0, 32'h0);
		wait_drained();
	endtask

	task automatic test_field_extremes();
		set_all(16'hffff, 16'hffff, 16'hffff, 24'hff_ffff);
		send_item(12'hfff, S32_MAX, S32_MIN);
		send_item(12'hfff, S32_MIN, S32_MAX);
		send_item(12'd0, S32_MIN, S32_MIN);
		send_item(12'd0, S32_MAX, S32_MAX);
		send_item(12'd1, 32'h0, S32_MIN);
		send_item(12'd1, 32'hffff_ffff, S32_MAX);
		wait_drained();
		set_all(16'd0, 16'd0, 16'd0, 24'd0);
		send_item(12'd7, S32_MAX, 32'h1234_5678);
		send_item(12'd7, S32_MIN, 32'h8765_4321);
		wait_drained();
	endtask

	task automatic test_zero_denominator();
		// no second moment growth and no offset: sqrt(v)+eps stays zero
		set_all(16'hffff, 16'd0, 16'd0, 24'h80_0000);
		send_item(12'd100, 32'h0003_0000, 32'h0);
		send_item(12'd101, 32'hfffd_0000, 32'h0);
		send_item(12'd102, 32'h0, 32'h0001_0000);
		send_item(12'd100, 32'h0, S32_MIN);
		send_item(12'd101, 32'h0, S32_MAX);
		wait_drained();
	endtask

	task automatic test_backpressure_fill();
		set_all(16'd6554, 16'd66, 16'd1, 24'd16777);
		no_idle = 1'b1;
		hold_request = 1'b1;
		for (int i = 0; i < 150; i++) send_item(IDX_W'(i % 8), random_gradient(), $urandom());
		no_idle = 1'b0;
		wait_drained();
	endtask

	task automatic run_random_phase(int count, int idx_span);
		logic [IDX_W-1:0] idx;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0) idx = IDX_W'($urandom());
			else idx = IDX_W'($urandom_range(0, idx_span - 1));
			send_item(idx, random_gradient(), $urandom());
		end
		wait_drained();
	endtask

	task automatic test_random_updates();
		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: set_all(16'd6554, 16'd66, 16'd1, 24'd16777);
				1: set_all(16'hffff, 16'hffff, 16'd0, 24'hff_ffff);
				2: set_all(16'd1, 16'd1, 16'hffff, 24'd1);
				default: set_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
						24'($urandom()));
			endcase
			no_idle = (phase == 3);
			run_random_phase(200, phase == 5 ? NUM_SLOTS : 32);
		end
		no_idle = 1'b0;
	endtask

	// result side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request <= 1'b0;
			hold_left <= 300;
			m_axis_tready <= 1'b0;
		end else if (no_idle) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) < 75) ||
				($urandom_range(0, 99) < 2 ? 1'b0 : 1'b0);
			if ($urandom_range(0, 199) == 0) hold_left <= $urandom_range(10, 40);
		end
	end

	always @(posedge clk) begin
		update_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[11:0], m_axis_tdata[43:12], m_axis_tdata[75:44]};
			if (pending_updates.size() == 0) begin
				$error("unexpected result item %h", m_axis_tdata);
				failed = 1'b1;
			end else begin
				want = pending_updates.pop_front();
				if (got.idx !== want.idx) begin
					$error("index_out expected %0d actual %0d", want.idx, got.idx);
					failed = 1'b1;
				end
				if (got.weight !== want.weight) begin
					$error("weight_out expected %h actual %h", want.weight, got.weight);
					failed = 1'b1;
				end
				if (got.step !== want.step) begin
					$error("scaled_step expected %h actual %h", want.step, got.step);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		#25_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BETA1;
		cfg_data = '0;
		failed = 1'b0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		hold_left = 0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			moment1[i] = 0;
			moment2[i] = 0;
		end
		blend1 = 16'd6554;
		blend2 = 16'd66;
		eps_val = 16'd1;
		rate_val = 24'd16777;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_field_extremes();
		test_zero_denominator();
		test_backpressure_fill();
		test_random_updates();
		wait_drained();
		if (!failed) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/apu_pkg.sv
hw/rtl/adam_parameter_update_unit.sv
verif/adam_parameter_update_unit_test.sv
